/* hdl/ehc_pkg.sv */
// Shared types, constants and elaboration-time helpers for the extended
// Hamming codec. Used by ehc_regs, ehc_codec and extended_hamming_codec_unit.
package ehc_pkg;

  // Fixed widths of the stream fields and the data size register
  localparam int unsigned WordWidth     = 64;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned DataSizeWidth = 6;
  localparam logic [DataSizeWidth-1:0] DataSizeReset = 6'd4;

  // Register index of data_size (byte address bit 2 selects the register)
  localparam logic RegDataSize = 1'b0;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_DOUBLE    = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Elaboration-time helpers; only ever called with constant arguments
  function automatic bit is_pow2(int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Number of powers of two not above k (capped at seven)
  function automatic int check_count(int k);
    int r;
    r = 0;
    while ((r < 7) && ((1 << r) <= k)) r++;
    return r;
  endfunction

  // Codeword position of data bit d: the d-th position at or above 3
  // that is not a power of two
  function automatic int data_pos(int d);
    int p;
    int cnt;
    p   = 3;
    cnt = 0;
    while (1) begin
      if (!is_pow2(p)) begin
        if (cnt == d) return p;
        cnt++;
      end
      p++;
    end
  endfunction

  // Data positions that exist below a codeword width w
  function automatic int data_slots(int w);
    int cnt;
    cnt = 0;
    for (int p = 3; p < w; p++) begin
      if (!is_pow2(p)) cnt++;
    end
    return cnt;
  endfunction

  // Largest data size whose codeword still fits in w positions
  function automatic int max_data_size(int w);
    int k;
    k = 63;
    while ((k > 1) && (k + check_count(k) + 1 > w)) k--;
    return k;
  endfunction

endpackage

/* hdl/ehc_regs.sv */
// Configuration register block: APB-style access to data_size; the derived
// codeword length n is driven on cw_len_o. Depends on ehc_pkg.
module ehc_regs
  import ehc_pkg::*;
#(
  parameter int unsigned CwWidth = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [$clog2(CwWidth+1)-1:0]     cw_len_o
);

  localparam int unsigned NW     = $clog2(CwWidth + 1);
  localparam int          KMax   = max_data_size(CwWidth);
  localparam int          NReset = int'(DataSizeReset) + check_count(int'(DataSizeReset)) + 1;

  logic [DataSizeWidth-1:0] data_size_q;
  logic [NW-1:0]            cw_len_q;
  logic [NW-1:0]            cw_len_d;
  logic [DataSizeWidth-1:0] k_eff;
  logic [2:0]               r_cnt;
  logic [7:0]               n_sum;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegDataSize);

  // Effective data size for n: zero counts as one, oversize clamps to the fit limit
  always_comb begin
    k_eff = pwdata[DataSizeWidth-1:0];
    if (k_eff == '0) begin
      k_eff = DataSizeWidth'(1);
    end else if (k_eff > DataSizeWidth'(KMax)) begin
      k_eff = DataSizeWidth'(KMax);
    end
    r_cnt = '0;
    for (int j = 0; j < DataSizeWidth; j++) begin
      r_cnt = r_cnt + 3'(k_eff >= DataSizeWidth'(1 << j));
    end
    n_sum    = 8'(k_eff) + 8'(r_cnt) + 8'd1;
    cw_len_d = NW'(n_sum);
  end

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q <= DataSizeReset;
      cw_len_q    <= NW'(NReset);
    end else if (wr_en) begin
      data_size_q <= pwdata[DataSizeWidth-1:0];
      cw_len_q    <= cw_len_d;
    end
  end

  // Readback
  assign prdata   = (paddr[2] == RegDataSize) ? 32'(data_size_q) : 32'd0;
  assign cw_len_o = cw_len_q;

endmodule

/* hdl/ehc_codec.sv */
// Combinational SECDED encode/decode datapath for one word.
// Depends on ehc_pkg; sits between the input and result registers.
module ehc_codec
  import ehc_pkg::*;
#(
  parameter int unsigned CwWidth = 64
) (
  input  cmd_e                             cmd_i,
  input  logic [CwWidth-1:0]               word_i,
  input  logic [$clog2(CwWidth+1)-1:0]     cw_len_i,
  output logic [WordWidth-1:0]             word_o,
  output status_e                          status_o
);

  localparam int unsigned NW = $clog2(CwWidth + 1);
  localparam int unsigned SW = $clog2(CwWidth);
  localparam int unsigned DS = data_slots(CwWidth);

  logic [CwWidth-1:0] in_range;
  logic [CwWidth-1:0] placed;
  logic [CwWidth-1:0] enc_body;
  logic [CwWidth-1:0] enc_cw;
  logic [CwWidth-1:0] dec_masked;
  logic [CwWidth-1:0] fixed;
  logic [SW-1:0]      enc_syn;
  logic [SW-1:0]      dec_syn;
  logic               dec_par;
  logic               flip_en;
  status_e            dec_status;
  logic [DS-1:0]      dec_data;

  // Position map: in range below n; data bits scattered to fixed slots
  for (genvar p = 0; p < CwWidth; p++) begin : g_pos
    assign in_range[p] = (NW'(p) < cw_len_i);
    if ((p < 3) || is_pow2(p)) begin : g_chk
      assign placed[p] = 1'b0;
    end else begin : g_dat
      assign placed[p] = word_i[p - 1 - $clog2(p)] & in_range[p];
    end
  end

  // Data extraction from the corrected codeword
  for (genvar d = 0; d < DS; d++) begin : g_ext
    assign dec_data[d] = fixed[data_pos(d)];
  end

  // Syndromes: each bit is the parity of positions whose index has that bit
  always_comb begin
    enc_syn = '0;
    dec_syn = '0;
    for (int j = 0; j < SW; j++) begin
      for (int p = 0; p < CwWidth; p++) begin
        if (p[j]) begin
          enc_syn[j] = enc_syn[j] ^ placed[p];
          dec_syn[j] = dec_syn[j] ^ dec_masked[p];
        end
      end
    end
  end

  // Encode: check bits cancel the syndrome, position 0 takes overall parity
  always_comb begin
    enc_body = placed;
    for (int j = 0; j < SW; j++) begin
      enc_body[1 << j] = enc_syn[j] & in_range[1 << j];
    end
    enc_cw = {enc_body[CwWidth-1:1], ^enc_body[CwWidth-1:1]};
  end

  // Decode: classify, then flip the named bit on a correctable error
  assign dec_masked = word_i & in_range;
  assign dec_par    = ^dec_masked;

  always_comb begin
    flip_en    = 1'b0;
    dec_status = ST_CLEAN;
    if (!dec_par) begin
      dec_status = (dec_syn == '0) ? ST_CLEAN : ST_DOUBLE;
    end else if (dec_syn == '0) begin
      // overall parity bit itself flipped
      dec_status = ST_CORRECTED;
    end else if (NW'(dec_syn) >= cw_len_i) begin
      dec_status = ST_RANGE;
    end else begin
      flip_en    = 1'b1;
      dec_status = ST_CORRECTED;
    end
  end

  always_comb begin
    for (int p = 0; p < CwWidth; p++) begin
      fixed[p] = dec_masked[p] ^ (flip_en && (dec_syn == SW'(p)));
    end
  end

  // Result select
  always_comb begin
    case (cmd_i)
      CMD_ENCODE: begin
        word_o   = WordWidth'(enc_cw);
        status_o = ST_CLEAN;
      end
      CMD_DECODE: begin
        word_o   = WordWidth'(dec_data);
        status_o = dec_status;
      end
      default: begin
        word_o   = '0;
        status_o = ST_CLEAN;
      end
    endcase
  end

endmodule

/* hdl/extended_hamming_codec_unit.sv */
// Top level of the extended Hamming (SECDED) codec: stream ports, input and
// result registers. Depends on ehc_pkg, ehc_regs and ehc_codec.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata=word_in, tuser=command
//  m_axis    out        m_axis_tvalid/tready      tdata=word_out, tuser=status
//  apb       in         psel/penable/pwrite       data_size at byte address 0
//
// One request per cycle sustained while m_axis_tready is high; a request
// passes the input register, one combinational codec pass and the result
// register, and m_axis_tvalid rises once the result register has taken it.
// Stalls: s_axis_tready drops only when both registers hold a
// request and m_axis_tready is low. Reset empties both stages and sets
// data_size to 4 (codeword length 8).
module extended_hamming_codec_unit
  import ehc_pkg::*;
#(
  parameter int unsigned CODEWORD_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [WordWidth-1:0]   s_axis_tdata,   // [63:0] word_in
  input  logic                   s_axis_tuser,   // [0] command
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [WordWidth-1:0]   m_axis_tdata,   // [63:0] word_out
  output logic [StatusWidth-1:0] m_axis_tuser,   // [1:0] status
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned NW = $clog2(CODEWORD_WIDTH + 1);

  logic                      s1_valid_q;
  cmd_e                      s1_cmd_q;
  logic [CODEWORD_WIDTH-1:0] s1_word_q;
  logic                      out_valid_q;
  logic [WordWidth-1:0]      out_word_q;
  status_e                   out_status_q;
  logic                      out_free;
  logic                      s1_free;
  logic [NW-1:0]             cw_len;
  logic [WordWidth-1:0]      codec_word;
  status_e                   codec_status;

  ehc_regs #(
    .CwWidth (CODEWORD_WIDTH)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cw_len_o (cw_len)
  );

  ehc_codec #(
    .CwWidth (CODEWORD_WIDTH)
  ) u_codec (
    .cmd_i    (s1_cmd_q),
    .word_i   (s1_word_q),
    .cw_len_i (cw_len),
    .word_o   (codec_word),
    .status_o (codec_status)
  );

  // Flow control: each stage moves when the one after it can take a request
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_free       = !s1_valid_q || out_free;
  assign s_axis_tready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_free && s_axis_tvalid) begin
      s1_cmd_q  <= cmd_e'(s_axis_tuser);
      s1_word_q <= s_axis_tdata[CODEWORD_WIDTH-1:0];
    end
    if (out_free && s1_valid_q) begin
      out_word_q   <= codec_word;
      out_status_q <= codec_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_status_q;

endmodule
